// ----- hw/rtl/mlfq_pkg.sv -----
// mlfq_pkg: shared constants and types for the multilevel feedback scheduler
// no dependencies
package mlfq_pkg;
  localparam int MaxJobs   = 16;
  localparam int NumLevels = 3;
  localparam int JobW      = 4;
  localparam int LvlW      = 2;
  localparam int SlotW     = 4;
  localparam int CntW      = 5;
  localparam int AddrW     = 6;
  localparam int RegW      = 14;
  localparam int RemW      = 16;
  localparam int TimeW     = 32;
  localparam int EntryW    = JobW + RemW + TimeW + RemW + RemW + 1;

  localparam logic [0:0] RegBaseSlice = 1'b0;
  localparam logic [0:0] RegTickStep  = 1'b1;

  typedef struct packed {
    logic [JobW-1:0]  job;
    logic [RemW-1:0]  rem;
    logic [TimeW-1:0] arr;
    logic [RemW-1:0]  burst;
    logic [RemW-1:0]  run;
    logic             pre;
  } entry_t;
endpackage

// ----- hw/rtl/multilevel_feedback_scheduler_unit.sv -----
// multilevel_feedback_scheduler_unit: three-level feedback queue scheduler
// queue entries held in one synchronous memory; depends on mlfq_pkg
//
// channel  dir  tdata (low bit up)                                      tuser
// in_      in   time_passes, arrival_valid, arrival_job, arrival_burst  -
// out_     out  running_valid, running_job, running_level, done_valid,
//               done_job, done_finish_time, done_wait_time, done_turnaround
// cfg_     in   index 0 base_slice, index 1 tick_step
//
// an item runs through these steps before the next input transfer is accepted: tick and
// demotion push, arrival push, preempt push, memory read and load of the popped job when
// a job is taken from a queue, result load; the single memory port gives each push its step
// rst_n is synchronous; queues empty and no job current after reset
// the result load waits while the result register still holds an untaken transfer
module multilevel_feedback_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // time_passes, arrival_valid, arrival_job, arrival_burst
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [111:0] out_tdata, // running_valid, running_job, running_level, done_valid,
                                  // done_job, done_finish_time, done_wait_time, done_turnaround
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [13:0] cfg_wdata
);
  typedef enum logic [2:0] {S_IDLE, S_ARR, S_PRE, S_RD, S_POP, S_OUT} state_t;

  localparam logic [mlfq_pkg::LvlW-1:0] LastLvl = mlfq_pkg::LvlW'(mlfq_pkg::NumLevels - 1);

  state_t state_r;
  logic [mlfq_pkg::RegW-1:0] base_r, step_r;
  logic [mlfq_pkg::TimeW-1:0] elapsed_r;
  logic cur_v_r;
  mlfq_pkg::entry_t cur_r;
  logic [mlfq_pkg::LvlW-1:0] cur_lvl_r;
  logic [mlfq_pkg::SlotW-1:0] head_r [mlfq_pkg::NumLevels];
  logic [mlfq_pkg::CntW-1:0]  cnt_r  [mlfq_pkg::NumLevels];
  logic arr_v_r, arr_ok_r;
  logic [mlfq_pkg::JobW-1:0] arr_job_r;
  logic [mlfq_pkg::RemW-1:0] arr_burst_r;
  logic [mlfq_pkg::LvlW-1:0] pop_lvl_r;
  logic [111:0] item_res_r;
  logic [111:0] res_r;
  logic out_v_r;

  mlfq_pkg::entry_t mem [mlfq_pkg::NumLevels * mlfq_pkg::MaxJobs];
  mlfq_pkg::entry_t rd_r;
  logic mem_we;
  logic [mlfq_pkg::AddrW-1:0] mem_wa, mem_ra;
  mlfq_pkg::entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  function automatic logic [mlfq_pkg::AddrW-1:0] addr_of(
      input logic [mlfq_pkg::LvlW-1:0] lv, input logic [mlfq_pkg::SlotW-1:0] s);
    return mlfq_pkg::AddrW'({lv, s});
  endfunction

  // tick arithmetic
  logic [mlfq_pkg::TimeW:0] t_sum;
  logic [mlfq_pkg::TimeW-1:0] t_new;
  logic [mlfq_pkg::RemW-1:0] rem_new, run_new;
  logic [mlfq_pkg::RemW:0] run_sum;
  logic [mlfq_pkg::RemW+2:0] q_raw;
  logic [mlfq_pkg::RemW-1:0] quant;
  logic [mlfq_pkg::TimeW-1:0] turn, waitt;
  logic [mlfq_pkg::LvlW-1:0] dest;
  logic tp, av;
  logic [mlfq_pkg::LvlW-1:0] first_lvl;
  logic any_q;
  logic [111:0] item_res_nxt;
  mlfq_pkg::entry_t cur_tick;

  assign tp = in_tdata[0];
  assign av = in_tdata[1];
  assign t_sum = {1'b0, elapsed_r} + (mlfq_pkg::TimeW+1)'(step_r);
  assign t_new = t_sum[mlfq_pkg::TimeW] ? '1 : t_sum[mlfq_pkg::TimeW-1:0];
  assign rem_new = (cur_r.rem > mlfq_pkg::RemW'(step_r)) ?
                   cur_r.rem - mlfq_pkg::RemW'(step_r) : '0;
  assign run_sum = {1'b0, cur_r.run} + (mlfq_pkg::RemW+1)'(step_r);
  assign run_new = run_sum[mlfq_pkg::RemW] ? '1 : run_sum[mlfq_pkg::RemW-1:0];
  assign q_raw = ((mlfq_pkg::RemW+3)'(base_r) << cur_lvl_r) >> cur_r.pre;
  assign quant = (q_raw > (mlfq_pkg::RemW+3)'(16'hFFFF)) ? '1 : q_raw[mlfq_pkg::RemW-1:0];
  assign turn = t_new - cur_r.arr;
  assign waitt = (turn >= mlfq_pkg::TimeW'(cur_r.burst)) ?
                 turn - mlfq_pkg::TimeW'(cur_r.burst) : '0;
  assign dest = (cur_lvl_r < LastLvl) ? cur_lvl_r + 1'b1 : cur_lvl_r;

  always_comb begin
    cur_tick = cur_r;
    cur_tick.rem = rem_new;
    cur_tick.run = run_new;
  end

  always_comb begin
    item_res_nxt = '0;
    if (tp && cur_v_r) begin
      item_res_nxt[0]   = 1'b1;
      item_res_nxt[4:1] = cur_r.job;
      item_res_nxt[6:5] = cur_lvl_r;
      if (rem_new == '0) begin
        item_res_nxt[7]       = 1'b1;
        item_res_nxt[11:8]    = cur_r.job;
        item_res_nxt[43:12]   = t_new;
        item_res_nxt[75:44]   = waitt;
        item_res_nxt[107:76]  = turn;
      end
    end
  end

  always_comb begin
    first_lvl = '0;
    any_q = 1'b0;
    for (int i = mlfq_pkg::NumLevels - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        first_lvl = mlfq_pkg::LvlW'(i);
        any_q = 1'b1;
      end
    end
  end

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = res_r;

  logic [mlfq_pkg::SlotW-1:0] head_m1;
  assign head_m1 = head_r[cur_lvl_r] - 1'b1;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = cur_r;
    mem_ra = addr_of(pop_lvl_r, head_r[pop_lvl_r]);
    case (state_r)
      S_IDLE: begin
        // demotion push happens on the accept edge
        mem_wa = addr_of(dest, head_r[dest] + mlfq_pkg::SlotW'(cnt_r[dest]));
        mem_wd.rem = rem_new;
        mem_wd.run = '0;
        mem_wd.pre = 1'b0;
        mem_we = in_tvalid && in_tready && tp && cur_v_r && rem_new != '0 &&
                 run_new >= quant && cnt_r[dest] < mlfq_pkg::CntW'(mlfq_pkg::MaxJobs);
      end
      S_ARR: begin
        mem_wa = addr_of('0, head_r[0] + mlfq_pkg::SlotW'(cnt_r[0]));
        mem_wd.job = arr_job_r;
        mem_wd.rem = arr_burst_r;
        mem_wd.arr = elapsed_r;
        mem_wd.burst = arr_burst_r;
        mem_wd.run = '0;
        mem_wd.pre = 1'b0;
        mem_we = arr_v_r && cnt_r[0] < mlfq_pkg::CntW'(mlfq_pkg::MaxJobs);
      end
      S_PRE: begin
        mem_wa = addr_of(cur_lvl_r, head_m1);
        mem_wd.pre = 1'b1;
        mem_we = arr_ok_r && cur_v_r && cur_lvl_r != '0 &&
                 cnt_r[cur_lvl_r] < mlfq_pkg::CntW'(mlfq_pkg::MaxJobs);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      base_r    <= 14'd10;
      step_r    <= 14'd10;
      elapsed_r <= '0;
      cur_v_r   <= 1'b0;
      cur_lvl_r <= '0;
      out_v_r   <= 1'b0;
      arr_v_r   <= 1'b0;
      arr_ok_r  <= 1'b0;
      pop_lvl_r <= '0;
      for (int i = 0; i < mlfq_pkg::NumLevels; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == mlfq_pkg::RegBaseSlice) base_r <= cfg_wdata;
        else step_r <= cfg_wdata;
      end
      if (out_v_r && out_tready && state_r != S_OUT) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            arr_v_r     <= av;
            arr_job_r   <= in_tdata[5:2];
            arr_burst_r <= in_tdata[21:6];
            item_res_r  <= item_res_nxt;
            state_r     <= S_ARR;
            if (tp) begin
              elapsed_r <= t_new;
              if (cur_v_r) begin
                cur_r <= cur_tick;
                if (rem_new == '0) begin
                  cur_v_r <= 1'b0;
                end else if (mem_we) begin
                  cnt_r[dest] <= cnt_r[dest] + 1'b1;
                  cur_v_r     <= 1'b0;
                end
              end
            end
          end
        end
        S_ARR: begin
          arr_ok_r <= mem_we;
          if (mem_we) cnt_r[0] <= cnt_r[0] + 1'b1;
          state_r <= S_PRE;
        end
        S_PRE: begin
          if (mem_we) begin
            head_r[cur_lvl_r] <= head_m1;
            cnt_r[cur_lvl_r]  <= cnt_r[cur_lvl_r] + 1'b1;
            cur_v_r           <= 1'b0;
          end
          if (!(cur_v_r && !mem_we) && (any_q || mem_we)) begin
            pop_lvl_r <= mem_we ? '0 : first_lvl;
            state_r   <= S_RD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_RD: state_r <= S_POP;
        S_POP: begin
          cur_r     <= rd_r;
          cur_v_r   <= 1'b1;
          cur_lvl_r <= pop_lvl_r;
          head_r[pop_lvl_r] <= head_r[pop_lvl_r] + 1'b1;
          cnt_r[pop_lvl_r]  <= cnt_r[pop_lvl_r] - 1'b1;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_r || out_tready) begin
            res_r   <= item_res_r;
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= mlfq_pkg::CntW'(mlfq_pkg::MaxJobs)) else $error("level 0 overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> cnt_r[pop_lvl_r] != '0) else $error("pop from empty level");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("accept while busy");
endmodule

// ----- bench/mlfq_sched_checker.sv -----
// mlfq_sched_checker: watches the item, result and register ports of the scheduler,
// predicts every result from its own copy of the queues and compares field by field
// depends on mlfq_pkg
`timescale 1ns / 1ps

module mlfq_sched_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [23:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [13:0]  cfg_wdata,
  output int           pending,
  output int           errors
);

  // packed from the top bit down, so running_valid lands in bit 0
  typedef struct packed {
    logic [31:0] turn_t;
    logic [31:0] wait_t;
    logic [31:0] fin_t;
    logic [3:0]  done_job;
    logic        done_v;
    logic [1:0]  run_lvl;
    logic [3:0]  run_job;
    logic        run_v;
  } sched_result_t;

  sched_result_t expected_results[$];

  logic [13:0] slice_reg, step_reg;
  logic [63:0] clock_now;
  logic        cur_v, cur_pre;
  logic [3:0]  cur_job;
  logic [15:0] cur_rem, cur_burst, cur_run;
  logic [63:0] cur_arr;
  logic [1:0]  cur_lvl;
  logic [3:0]  q_job[mlfq_pkg::NumLevels][mlfq_pkg::MaxJobs];
  logic [15:0] q_rem[mlfq_pkg::NumLevels][mlfq_pkg::MaxJobs];
  logic [63:0] q_arr[mlfq_pkg::NumLevels][mlfq_pkg::MaxJobs];
  logic [15:0] q_burst[mlfq_pkg::NumLevels][mlfq_pkg::MaxJobs];
  logic [15:0] q_run[mlfq_pkg::NumLevels][mlfq_pkg::MaxJobs];
  logic        q_pre[mlfq_pkg::NumLevels][mlfq_pkg::MaxJobs];
  int          q_head[mlfq_pkg::NumLevels];
  int          q_cnt[mlfq_pkg::NumLevels];

  assign pending = expected_results.size();

  initial errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit enqueue_tail(int lv, logic [3:0] job, logic [15:0] rem,
                                      logic [63:0] arr, logic [15:0] burst);
    int slot;
    if (q_cnt[lv] >= mlfq_pkg::MaxJobs) return 0;
    slot = (q_head[lv] + q_cnt[lv]) % mlfq_pkg::MaxJobs;
    q_job[lv][slot] = job;
    q_rem[lv][slot] = rem;
    q_arr[lv][slot] = arr;
    q_burst[lv][slot] = burst;
    q_run[lv][slot] = '0;
    q_pre[lv][slot] = 1'b0;
    q_cnt[lv]++;
    return 1;
  endfunction

  function automatic bit requeue_front();
    int lv;
    lv = cur_lvl;
    if (q_cnt[lv] >= mlfq_pkg::MaxJobs) return 0;
    q_head[lv] = (q_head[lv] == 0) ? mlfq_pkg::MaxJobs - 1 : q_head[lv] - 1;
    q_job[lv][q_head[lv]] = cur_job;
    q_rem[lv][q_head[lv]] = cur_rem;
    q_arr[lv][q_head[lv]] = cur_arr;
    q_burst[lv][q_head[lv]] = cur_burst;
    q_run[lv][q_head[lv]] = cur_run;
    q_pre[lv][q_head[lv]] = 1'b1;
    q_cnt[lv]++;
    return 1;
  endfunction

  function automatic void dispatch(int lv);
    int slot;
    slot = q_head[lv];
    cur_v = 1'b1;
    cur_job = q_job[lv][slot];
    cur_rem = q_rem[lv][slot];
    cur_arr = q_arr[lv][slot];
    cur_burst = q_burst[lv][slot];
    cur_run = q_run[lv][slot];
    cur_pre = q_pre[lv][slot];
    cur_lvl = 2'(lv);
    q_head[lv] = (slot + 1) % mlfq_pkg::MaxJobs;
    q_cnt[lv]--;
  endfunction

  function automatic logic [15:0] quantum(logic [1:0] lv, logic pre);
    logic [63:0] q;
    q = 64'(slice_reg) << lv;
    if (pre) q = q >> 1;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] t);
    return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic sched_result_t schedule_event(logic [23:0] d);
    sched_result_t r;
    logic [63:0]   t, turn, wt;
    logic [31:0]   run;
    int            dest;
    r = '0;
    if (d[0]) begin
      t = clock_now + 64'(step_reg);
      clock_now = (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
      if (cur_v) begin
        r.run_v = 1'b1;
        r.run_job = cur_job;
        r.run_lvl = cur_lvl;
        cur_rem = (cur_rem > 16'(step_reg)) ? cur_rem - 16'(step_reg) : 16'd0;
        run = 32'(cur_run) + 32'(step_reg);
        cur_run = (run > 32'hFFFF) ? 16'hFFFF : run[15:0];
        if (cur_rem == 0) begin
          turn = clock_now - cur_arr;
          wt = (turn >= 64'(cur_burst)) ? turn - 64'(cur_burst) : 64'd0;
          r.done_v = 1'b1;
          r.done_job = cur_job;
          r.fin_t = sat32(clock_now);
          r.wait_t = sat32(wt);
          r.turn_t = sat32(turn);
          cur_v = 1'b0;
        end else if (cur_run >= quantum(cur_lvl, cur_pre)) begin
          dest = (cur_lvl + 1 < mlfq_pkg::NumLevels) ? cur_lvl + 1 : cur_lvl;
          if (enqueue_tail(dest, cur_job, cur_rem, cur_arr, cur_burst)) cur_v = 1'b0;
        end
      end
    end
    if (d[1] && enqueue_tail(0, d[5:2], d[21:6], clock_now, d[21:6])) begin
      if (cur_v && cur_lvl > 0 && requeue_front()) dispatch(0);
    end
    if (!cur_v) begin
      for (int lv = 0; lv < mlfq_pkg::NumLevels; lv++) begin
        if (q_cnt[lv] > 0) begin
          dispatch(lv);
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t got, want, pred;
    if (!rst_n) begin
      slice_reg = 14'd10;
      step_reg = 14'd10;
      clock_now = '0;
      cur_v = 1'b0;
      cur_pre = 1'b0;
      cur_job = '0;
      cur_rem = '0;
      cur_burst = '0;
      cur_run = '0;
      cur_arr = '0;
      cur_lvl = '0;
      for (int lv = 0; lv < mlfq_pkg::NumLevels; lv++) begin
        q_head[lv] = 0;
        q_cnt[lv] = 0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == mlfq_pkg::RegBaseSlice) slice_reg = cfg_wdata;
        else if (cfg_index == mlfq_pkg::RegTickStep) step_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        pred = schedule_event(in_tdata);
        expected_results.insert(expected_results.size(), pred);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[107:0];
        if (expected_results.size() == 0) begin
          report("unexpected result transfer", 64'd1, 64'd0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.run_v !== want.run_v) report("running_valid", got.run_v, want.run_v);
          if (got.run_job !== want.run_job) report("running_job", got.run_job, want.run_job);
          if (got.run_lvl !== want.run_lvl) report("running_level", got.run_lvl, want.run_lvl);
          if (got.done_v !== want.done_v) report("done_valid", got.done_v, want.done_v);
          if (got.done_job !== want.done_job) report("done_job", got.done_job, want.done_job);
          if (got.fin_t !== want.fin_t) report("done_finish_time", got.fin_t, want.fin_t);
          if (got.wait_t !== want.wait_t) report("done_wait_time", got.wait_t, want.wait_t);
          if (got.turn_t !== want.turn_t) report("done_turnaround", got.turn_t, want.turn_t);
        end
      end
    end
  end

endmodule

// ----- bench/tb_multilevel_feedback_scheduler_unit.sv -----
// tb_multilevel_feedback_scheduler_unit: stimulus and verdict for the scheduler unit
// directed then random ticks and arrivals over several register settings
// depends on mlfq_pkg, mlfq_sched_checker and multilevel_feedback_scheduler_unit
`timescale 1ns / 1ps

module tb_multilevel_feedback_scheduler_unit;

  localparam int IdleLimit = 20000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;   // time_passes, arrival_valid, arrival_job, arrival_burst
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;       // running_valid, running_job, running_level, done_valid,
                                 // done_job, done_finish_time, done_wait_time, done_turnaround
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = mlfq_pkg::RegBaseSlice;
  logic [13:0]  cfg_wdata = '0;
  int           pending, errors;
  int           idle_cycles = 0;
  int           hold_request = 0;
  bit           no_idle = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multilevel_feedback_scheduler_unit dut (.*);

  mlfq_sched_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("multilevel_feedback_scheduler_unit test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // receiver side: random stalls, plus long hold-offs on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else if (no_idle) begin
        out_tready = 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 3) hold = $urandom_range(20, 60);
        out_tready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic logic [23:0] pack_item(bit tp, bit av, logic [3:0] job,
                                            logic [15:0] burst);
    return {2'b00, burst, job, av, tp};
  endfunction

  task automatic send_item(input logic [23:0] d);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk) in_tvalid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [13:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk) cfg_we = 1'b0;
  endtask

  function automatic logic [15:0] pick_burst(logic [13:0] step);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'd0;
    if (r < 8) return 16'hFFFF;
    if (r < 70) return 16'($urandom_range(1, 6 * (step == 0 ? 1 : step)));
    return 16'($urandom);
  endfunction

  task automatic random_phase(input int n, input logic [13:0] step);
    int cnt, k;
    cnt = 0;
    while (cnt < n) begin
      k = $urandom_range(0, 99);
      if (k < 80) begin
        send_item(pack_item($urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0,
                            4'($urandom), pick_burst(step)));
        cnt++;
      end else if (k < 88) begin
        // flood level 0 toward and past its depth
        repeat ($urandom_range(14, 20)) begin
          send_item(pack_item(1'b0, 1'b1, 4'($urandom), pick_burst(step)));
          cnt++;
        end
      end else begin
        send_item(24'($urandom) & 24'h3F_FFFF);
        cnt++;
      end
    end
  endtask

  initial begin
    logic [13:0] slices[6];
    logic [13:0] steps[6];
    slices = '{14'd10, 14'd1, 14'd16383, 14'd0, 14'd3, 14'd7};
    steps  = '{14'd10, 14'd1, 14'd10000, 14'd5, 14'd0, 14'd16383};
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    write_reg(mlfq_pkg::RegBaseSlice, 14'd10);
    write_reg(mlfq_pkg::RegTickStep, 14'd10);
    // directed: idle tick, arrival only, zero burst, demotion, preemption, overshoot
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b0, 1'b1, 4'd0, 16'd0));
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b0, 1'b1, 4'd15, 16'hFFFF));
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b1, 1'b1, 4'd1, 16'd5));
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b1, 1'b1, 4'd2, 16'd25));
    send_item(pack_item(1'b1, 1'b1, 4'd3, 16'd10));
    send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    send_item(pack_item(1'b1, 1'b1, 4'd4, 16'hAAAA));
    send_item(pack_item(1'b1, 1'b1, 4'd5, 16'h5555));
    repeat (6) send_item(pack_item(1'b1, 1'b0, 4'd0, 16'd0));
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(mlfq_pkg::RegBaseSlice, slices[p]);
      write_reg(mlfq_pkg::RegTickStep, steps[p]);
      no_idle = (p == 2);
      if (p == 1) begin
        hold_request = 300;
        random_phase(40, steps[p]);
        drain();
      end
      random_phase(200, steps[p]);
      drain();
    end

    @(negedge clk) in_tvalid = 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("multilevel_feedback_scheduler_unit test passed");
    end else begin
      $display("multilevel_feedback_scheduler_unit test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mlfq_pkg.sv
hw/rtl/multilevel_feedback_scheduler_unit.sv
bench/mlfq_sched_checker.sv
bench/tb_multilevel_feedback_scheduler_unit.sv
